// ===== src/dashed_polyline_segmenter_macros.svh =====
// Assertion macros shared by the dashed polyline segmenter RTL.
`ifndef DASHED_POLYLINE_SEGMENTER_MACROS_SVH
`define DASHED_POLYLINE_SEGMENTER_MACROS_SVH
`ifndef SYNTHESIS
`define DPS_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dps: same-cycle check failed");
`define DPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dps: next-cycle check failed");
`else
`define DPS_ASSERT(lbl, clk, rstn, ante, cons)
`define DPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/dps_pkg.sv =====
// Types, constants and helpers of the dashed polyline segmenter.
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;

  localparam int NumLenRegs = 6;
  localparam int LenW       = 16;
  localparam int CntW       = 3;
  localparam int CfgIdxW    = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDashCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDashLen0  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDashLen5  = 3'd6;

  localparam logic [LenW-1:0] LenResetVal = 16'd16;

  typedef logic [NumLenRegs-1:0][LenW-1:0] dps_len_arr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SOLID,
    ST_SQRT_GO,
    ST_SQRT,
    ST_WALK1,
    ST_WALK2,
    ST_COORD_GO,
    ST_COORD,
    ST_EMIT
  } dps_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MULX,
    SQ_MULY,
    SQ_ITER,
    SQ_ROUND
  } dps_sqrt_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } dps_md_state_e;

  // Pattern length lookup: out-of-range entries and zero lengths read as one
  function automatic logic [LenW-1:0] len_sel(dps_len_arr_t lens, logic [CntW-1:0] idx);
    logic [LenW-1:0] v;
    v = (idx < CntW'(NumLenRegs)) ? lens[idx] : '0;
    if (v == '0) begin
      v = LenW'(1);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/dps_if.sv =====
// Channel interfaces: vertex input, segment output and register write.
`timescale 1ns / 1ps
`default_nettype none
interface dps_point_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic                point_null;
  logic                first_point;
  modport source (output valid, point_x, point_y, point_null, first_point, input ready);
  modport sink (input valid, point_x, point_y, point_null, first_point, output ready);
endinterface

interface dps_seg_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] seg_x0;
  logic signed [W-1:0] seg_y0;
  logic signed [W-1:0] seg_x1;
  logic signed [W-1:0] seg_y1;
  logic                last_piece;
  logic                truncated;
  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, last_piece, truncated,
                  input ready);
  modport sink (input valid, seg_x0, seg_y0, seg_x1, seg_y1, last_piece, truncated,
                output ready);
endinterface

interface dps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/dashed_polyline_segmenter.sv =====
// Top level: vertex sequencer, dash pattern walker and segment output register.
`timescale 1ns / 1ps
`default_nettype none
`include "dashed_polyline_segmenter_macros.svh"
// One vertex is taken at a time; in_i.ready is high only while the sequencer
// idles. A dashed edge first gets its length (both axes squared, one root bit
// per cycle, rounding), then a first walk over the pattern pieces counts the
// drawn pieces, then a second walk sends each drawn piece through the shared
// multiply/divide unit (one quotient bit per cycle) and steps over gap pieces.
// The count pass lets truncated be flagged on every piece of a cut edge. The
// last piece of a vertex waits in the output register while the next vertex
// is taken.
module dashed_polyline_segmenter import dps_pkg::*; #(
  parameter int MAX_DASHES = 6,
  parameter int MAX_PIECES = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dps_point_if.sink   in_i,
  dps_seg_if.source   out_o,
  dps_cfg_if.sink     cfg_i
);
  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int XW  = (DW > LenW) ? DW : LenW;
  localparam int PCW = $clog2(MAX_PIECES + 1);
  localparam logic [CntW-1:0] MaxDash   = CntW'(MAX_DASHES);
  localparam logic [PCW-1:0]  MaxPieces = PCW'(MAX_PIECES);

  dps_state_e state_q, state_d;

  // Configuration
  logic [CntW-1:0] dash_count_q;
  dps_len_arr_t    lens_q;
  logic [CntW-1:0] cnt;

  // Vertex and edge
  logic signed [C-1:0] px_q, py_q, bx_q, by_q;
  logic                bv_q;
  logic [C-1:0]        mx_q, my_q;
  logic                sx_q, sy_q;
  logic signed [C:0]   dx, dy;
  logic [DW-1:0]       d_q;

  // Pattern state and walk
  logic [CntW-1:0] pidx_q, w_idx_q;
  logic [LenW-1:0] prem_q, w_rem_q;
  logic [DW-1:0]   pos_q;
  logic [PCW-1:0]  n1_q, emit_cnt_q;
  logic            cut_q;

  // Piece coordinates
  logic [1:0]   cidx_q;
  logic [C-1:0] pc_q [4];

  // Output register
  logic         out_vld_q, out_load, out_free;
  logic [C-1:0] ox0_q, oy0_q, ox1_q, oy1_q;
  logic         olast_q, otrunc_q;

  // Unit handshakes
  logic         sqrt_start, sqrt_done, md_start, md_done;
  logic [DW-1:0] root;
  logic [C-1:0] md_q, md_m, base, coord;
  logic [DW-1:0] md_t;
  logic         in_acc, in_ready;

  // Step of the dash walk
  logic [LenW-1:0] rem_eff, nlen, rem_part;
  logic [DW-1:0]   avail, step_end;
  logic            full, more, drawn;
  logic [CntW:0]   inc_idx;
  logic [CntW-1:0] nidx;

  assign cnt     = (dash_count_q > MaxDash) ? MaxDash : dash_count_q;
  assign in_acc  = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_free = !out_vld_q || out_o.ready;

  assign dx = (C+1)'(in_i.point_x) - (C+1)'(bx_q);
  assign dy = (C+1)'(in_i.point_y) - (C+1)'(by_q);

  assign rem_eff  = (w_rem_q == '0) ? LenW'(1) : w_rem_q;
  assign avail    = d_q - pos_q;
  assign full     = XW'(rem_eff) <= XW'(avail);
  assign step_end = full ? DW'(XW'(pos_q) + XW'(rem_eff)) : d_q;
  assign inc_idx  = {1'b0, w_idx_q} + (CntW+1)'(1);
  assign nidx     = (inc_idx >= {1'b0, cnt}) ? '0 : inc_idx[CntW-1:0];
  assign nlen     = len_sel(lens_q, nidx);
  assign rem_part = rem_eff - LenW'(XW'(avail));
  assign more     = pos_q < d_q;
  assign drawn    = !w_idx_q[0];

  // Operands of the scaling unit and the finished coordinate
  assign md_m  = cidx_q[0] ? my_q : mx_q;
  assign md_t  = cidx_q[1] ? step_end : pos_q;
  assign base  = cidx_q[0] ? by_q : bx_q;
  assign coord = (cidx_q[0] ? sy_q : sx_q) ? base - md_q : base + md_q;

  dps_sqrt #(.MW(C)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .ax_i    (mx_q),
    .ay_i    (my_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  dps_muldiv #(.MW(C)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .m_i     (md_m),
    .t_i     (md_t),
    .d_i     (d_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    sqrt_start = 1'b0;
    md_start   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && !in_i.point_null && !in_i.first_point && bv_q) begin
          state_d = (cnt == '0) ? ST_SOLID : ST_SQRT_GO;
        end
      end
      ST_SOLID: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT;
      end
      ST_SQRT: if (sqrt_done) state_d = ST_WALK1;
      ST_WALK1: begin
        if (!more || (drawn && n1_q == MaxPieces)) state_d = ST_WALK2;
      end
      ST_WALK2: begin
        if (!more || (drawn && emit_cnt_q == MaxPieces)) begin
          state_d = ST_IDLE;
        end else if (drawn) begin
          state_d = ST_COORD_GO;
        end
      end
      ST_COORD_GO: begin
        md_start = 1'b1;
        state_d  = ST_COORD;
      end
      ST_COORD: begin
        if (md_done) state_d = (cidx_q == 2'd3) ? ST_EMIT : ST_COORD_GO;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_WALK2;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state: registers, pattern, walk counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_count_q <= '0;
      lens_q       <= {NumLenRegs{LenResetVal}};
      bv_q         <= 1'b0;
      pidx_q       <= '0;
      prem_q       <= LenResetVal;
      w_idx_q      <= '0;
      w_rem_q      <= LenResetVal;
      pos_q        <= '0;
      n1_q         <= '0;
      emit_cnt_q   <= '0;
      cut_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      // Register writes
      if (cfg_i.valid) begin
        if (cfg_i.index == RegDashCount) begin
          dash_count_q <= cfg_i.data[CntW-1:0];
        end else if (cfg_i.index >= RegDashLen0 && cfg_i.index <= RegDashLen5) begin
          lens_q[CntW'(cfg_i.index - RegDashLen0)] <= cfg_i.data;
        end
      end
      // Vertex bookkeeping
      if (in_acc) begin
        if (in_i.first_point) begin
          pidx_q <= '0;
          prem_q <= len_sel(lens_q, '0);
        end
        if (in_i.point_null) begin
          bv_q <= 1'b0;
        end else if (in_i.first_point || !bv_q) begin
          bv_q <= 1'b1;
        end
      end
      // Start the counting walk from the held pattern state
      if (state_q == ST_SQRT && sqrt_done) begin
        w_idx_q <= pidx_q;
        w_rem_q <= prem_q;
        pos_q   <= '0;
        n1_q    <= '0;
        cut_q   <= 1'b0;
      end
      if (state_q == ST_WALK1) begin
        if (state_d == ST_WALK2) begin
          if (more) cut_q <= 1'b1;
          w_idx_q    <= pidx_q;
          w_rem_q    <= prem_q;
          pos_q      <= '0;
          emit_cnt_q <= '0;
        end else begin
          if (drawn) n1_q <= n1_q + PCW'(1);
          w_idx_q <= full ? nidx : w_idx_q;
          w_rem_q <= full ? nlen : rem_part;
          pos_q   <= step_end;
        end
      end
      // Emitting walk: advance over gaps and after each issued piece
      if (state_q == ST_WALK2) begin
        if (state_d == ST_IDLE) begin
          pidx_q <= w_idx_q;
          prem_q <= w_rem_q;
        end else if (!drawn) begin
          w_idx_q <= full ? nidx : w_idx_q;
          w_rem_q <= full ? nlen : rem_part;
          pos_q   <= step_end;
        end
      end
      if (state_q == ST_EMIT && out_free) begin
        emit_cnt_q <= emit_cnt_q + PCW'(1);
        w_idx_q    <= full ? nidx : w_idx_q;
        w_rem_q    <= full ? nlen : rem_part;
        pos_q      <= step_end;
      end
      // Output valid
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_i.point_x;
      py_q <= in_i.point_y;
      mx_q <= dx[C] ? C'(-dx) : C'(dx);
      my_q <= dy[C] ? C'(-dy) : C'(dy);
      sx_q <= dx[C];
      sy_q <= dy[C];
      if (!in_i.point_null && (in_i.first_point || !bv_q)) begin
        bx_q <= in_i.point_x;
        by_q <= in_i.point_y;
      end
    end
    if (state_q == ST_SOLID && out_free) begin
      ox0_q    <= bx_q;
      oy0_q    <= by_q;
      ox1_q    <= px_q;
      oy1_q    <= py_q;
      olast_q  <= 1'b1;
      otrunc_q <= 1'b0;
      bx_q     <= px_q;
      by_q     <= py_q;
    end
    if (state_q == ST_SQRT && sqrt_done) begin
      d_q <= root;
    end
    if (state_q == ST_WALK2) begin
      cidx_q <= '0;
      if (state_d == ST_IDLE) begin
        bx_q <= px_q;
        by_q <= py_q;
      end
    end
    if (state_q == ST_COORD && md_done) begin
      pc_q[cidx_q] <= coord;
      cidx_q       <= cidx_q + 2'd1;
    end
    if (state_q == ST_EMIT && out_free) begin
      ox0_q    <= pc_q[0];
      oy0_q    <= pc_q[1];
      ox1_q    <= pc_q[2];
      oy1_q    <= pc_q[3];
      olast_q  <= (emit_cnt_q + PCW'(1)) == n1_q;
      otrunc_q <= cut_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.seg_x0     = ox0_q;
  assign out_o.seg_y0     = oy0_q;
  assign out_o.seg_x1     = ox1_q;
  assign out_o.seg_y1     = oy1_q;
  assign out_o.last_piece = olast_q;
  assign out_o.truncated  = otrunc_q;

  // Checks
  `DPS_ASSERT(a_emit_bound, clk_i, rst_ni, state_q == ST_EMIT, emit_cnt_q < n1_q)
  `DPS_ASSERT(a_pos_bound, clk_i, rst_ni, state_q == ST_WALK1 || state_q == ST_WALK2, pos_q <= d_q)
  `DPS_ASSERT(a_cut_full, clk_i, rst_ni, cut_q && state_q == ST_WALK2, n1_q == MaxPieces)
  `DPS_ASSERT_NEXT(a_commit, clk_i, rst_ni, state_q == ST_WALK2 && state_d == ST_IDLE, pidx_q == $past(w_idx_q))
endmodule
`default_nettype wire

// ===== src/dps_sqrt.sv =====
// Edge length unit: squares both inputs in turn, then a bit-pair square root.
`timescale 1ns / 1ps
`default_nettype none
module dps_sqrt import dps_pkg::*; #(
  parameter int MW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [MW-1:0] ax_i,
  input  wire logic [MW-1:0] ay_i,
  output logic               done_o,
  output logic [MW:0]        root_o
);
  localparam int SW = 2 * MW + 2;

  dps_sqrt_state_e st_q, st_d;
  logic [MW-1:0] ax_q, ay_q;
  logic [SW-1:0] x_q, r_q, bit_q;
  logic [SW-1:0] rb;
  logic          ge;
  logic          done_q;
  logic [MW:0]   root_q;

  assign rb = r_q + bit_q;
  assign ge = x_q >= rb;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SQ_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == SQ_ROUND);
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      SQ_IDLE:  if (start_i) st_d = SQ_MULX;
      SQ_MULX:  st_d = SQ_MULY;
      SQ_MULY:  st_d = SQ_ITER;
      SQ_ITER:  if (bit_q[0]) st_d = SQ_ROUND;
      SQ_ROUND: st_d = SQ_IDLE;
      default:  st_d = SQ_IDLE;
    endcase
  end

  // Square, accumulate, then one root bit per cycle
  always_ff @(posedge clk_i) begin
    case (st_q)
      SQ_IDLE: begin
        ax_q <= ax_i;
        ay_q <= ay_i;
      end
      SQ_MULX: x_q <= SW'(ax_q) * SW'(ax_q);
      SQ_MULY: begin
        x_q   <= x_q + SW'(ay_q) * SW'(ay_q);
        r_q   <= '0;
        bit_q <= SW'(1) << (SW - 2);
      end
      SQ_ITER: begin
        if (ge) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      SQ_ROUND: root_q <= (x_q > r_q) ? (MW+1)'(r_q + SW'(1)) : (MW+1)'(r_q);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ===== src/dps_muldiv.sv =====
// Scaling unit: round(m * t / d) by one multiply and a restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module dps_muldiv import dps_pkg::*; #(
  parameter int MW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [MW-1:0] m_i,
  input  wire logic [MW:0]   t_i,
  input  wire logic [MW:0]   d_i,
  output logic               done_o,
  output logic [MW-1:0]      q_o
);
  localparam int DW = MW + 1;
  localparam int NW = MW + DW + 1;
  localparam int CW = $clog2(MW);

  dps_md_state_e st_q, st_d;
  logic [MW-1:0] m_q, low_q;
  logic [DW-1:0] t_q, d_q, rem_q;
  logic [NW-1:0] num;
  logic [DW:0]   trial;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          last_iter;
  logic          done_q;

  assign num       = NW'(m_q) * NW'(t_q) + NW'(d_q >> 1);
  assign trial     = {rem_q, low_q[MW-1]};
  assign ge        = trial >= {1'b0, d_q};
  assign last_iter = (cnt_q == CW'(MW - 1));

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == MD_DIV) && last_iter;
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      MD_IDLE: if (start_i) st_d = MD_MUL;
      MD_MUL:  st_d = MD_DIV;
      MD_DIV:  if (last_iter) st_d = MD_IDLE;
      default: st_d = MD_IDLE;
    endcase
  end

  // Quotient stays below 2^MW, so the top part of the product starts below d
  always_ff @(posedge clk_i) begin
    case (st_q)
      MD_IDLE: begin
        m_q <= m_i;
        t_q <= t_i;
        d_q <= d_i;
      end
      MD_MUL: begin
        rem_q <= num[MW+DW-1:MW];
        low_q <= num[MW-1:0];
        cnt_q <= '0;
      end
      MD_DIV: begin
        rem_q <= ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
        low_q <= {low_q[MW-2:0], ge};
        cnt_q <= cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = low_q;
endmodule
`default_nettype wire
